### src/sphere_overlap_table_defines.svh
// Assertion macros shared by the sphere overlap table RTL.
`ifndef SPHERE_OVERLAP_TABLE_DEFINES_SVH
`define SPHERE_OVERLAP_TABLE_DEFINES_SVH

// Checked after reset is released.
`define SOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define SOT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/sot_pkg.sv
// Types and constants for the sphere overlap table.
package sot_pkg;

    localparam int COORD_WIDTH     = 18;
    localparam int RADIUS_WIDTH    = 13;
    localparam int COUNT_OUT_WIDTH = 7;

    typedef struct packed {
        logic [COORD_WIDTH-1:0]  centre_x;
        logic [COORD_WIDTH-1:0]  centre_y;
        logic [COORD_WIDTH-1:0]  centre_z;
        logic [RADIUS_WIDTH-1:0] radius;
    } sot_in_t;

    typedef struct packed {
        logic                       overlaps;
        logic                       stored;
        logic [COUNT_OUT_WIDTH-1:0] entry_count;
    } sot_out_t;

    localparam int ENTRY_WIDTH = $bits(sot_in_t);

    typedef struct packed {
        logic busy;
        logic hit_valid;
        logic hit;
    } sot_cmp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } sot_state_t;

endpackage

### src/sot_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sot_ram #(
    parameter int WIDTH      = 8,
    parameter int DEPTH      = 16,
    parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/sot_cmp.sv
// Four-stage pipelined sphere-pair overlap compare.
module sot_cmp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  sot_pkg::sot_in_t            cand,
    input  sot_pkg::sot_in_t            entry,
    output sot_pkg::sot_cmp_status_t    status
);
    import sot_pkg::*;

    localparam int SQ_W  = 2 * COORD_WIDTH;
    localparam int RS_W  = RADIUS_WIDTH + 1;
    localparam int RS2_W = 2 * RS_W;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic [COORD_WIDTH-1:0]  dx_reg, dy_reg, dz_reg;
    logic [RS_W-1:0]         rs_reg;
    logic [SQ_W-1:0]         sqx_reg, sqy_reg, sqz_reg, sqz3_reg;
    logic [RS2_W-1:0]        rs2_reg, rs23_reg;
    logic [SQ_W:0]           sxy_reg;
    logic                    hit_reg;

    logic [COORD_WIDTH-1:0]  dx_next, dy_next, dz_next;
    logic [SQ_W+1:0]         dist_sum;

    always_comb begin
        dx_next = (cand.centre_x >= entry.centre_x) ? cand.centre_x - entry.centre_x
                                                    : entry.centre_x - cand.centre_x;
        dy_next = (cand.centre_y >= entry.centre_y) ? cand.centre_y - entry.centre_y
                                                    : entry.centre_y - cand.centre_y;
        dz_next = (cand.centre_z >= entry.centre_z) ? cand.centre_z - entry.centre_z
                                                    : entry.centre_z - cand.centre_z;
        dist_sum = {1'b0, sxy_reg} + (SQ_W+2)'(sqz3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dz_reg   <= dz_next;
        rs_reg   <= RS_W'(cand.radius) + RS_W'(entry.radius);
        sqx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        sqz_reg  <= SQ_W'(dz_reg) * SQ_W'(dz_reg);
        rs2_reg  <= RS2_W'(rs_reg) * RS2_W'(rs_reg);
        sxy_reg  <= (SQ_W+1)'(sqx_reg) + (SQ_W+1)'(sqy_reg);
        sqz3_reg <= sqz_reg;
        rs23_reg <= rs2_reg;
        hit_reg  <= dist_sum < (SQ_W+2)'(rs23_reg);
    end

    assign status.busy      = v1_reg | v2_reg | v3_reg | v4_reg;
    assign status.hit_valid = v4_reg;
    assign status.hit       = hit_reg;

endmodule

### src/sphere_overlap_table.sv
// Sphere overlap table top level: entry RAM, scan sequencer and result register.
// Each accepted item is compared against every stored entry before the next item is
// accepted: the scan reads one RAM entry a cycle into a four-stage compare pipeline,
// the drain state waits for it to empty, then the write state appends the candidate
// if it hit nothing and the table is not full; a stalled result holds the next.
// Reset: synchronous, active low; table empty, no result pending, no RAM sweep.
`include "sphere_overlap_table_defines.svh"

module sphere_overlap_table #(
    parameter int CAPACITY = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sot_pkg::sot_in_t   s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sot_pkg::sot_out_t  m_item
);
    import sot_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    sot_state_t       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic             hit_reg, hit_next;
    logic             rd_valid_reg;
    sot_in_t          cand_reg, cand_next;
    sot_out_t         res_reg, res_next;
    sot_out_t         m_item_reg, m_item_next;
    logic             m_valid_reg, m_valid_next;

    logic             rd_en, wr_en, res_load, out_load, accept;
    logic [ENTRY_WIDTH-1:0] rd_data;
    sot_cmp_status_t  cmp_status;

    sot_ram #(
        .WIDTH      (ENTRY_WIDTH),
        .DEPTH      (CAPACITY),
        .ADDR_WIDTH (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (cand_reg),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    sot_cmp u_cmp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (rd_valid_reg),
        .cand     (cand_reg),
        .entry    (sot_in_t'(rd_data)),
        .status   (cmp_status)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_SCAN;
            ST_SCAN:  if (issue_reg == count_reg) state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_valid_reg && !cmp_status.busy) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        res_load = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_SCAN:  rd_en = (issue_reg != count_reg);
            ST_DRAIN: ;
            ST_WRITE: begin
                res_load = 1'b1;
                wr_en    = !hit_reg && (count_reg != CAP_C);
            end
            ST_DONE:  out_load = !m_valid_reg || m_ready;
            default:  ;
        endcase
    end

    assign accept = s_valid && s_ready;

    always_comb begin
        cand_next    = accept ? s_item : cand_reg;
        issue_next   = issue_reg;
        hit_next     = hit_reg;
        count_next   = count_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg;
        if (accept) begin
            issue_next = '0;
            hit_next   = 1'b0;
        end else if (rd_en) begin
            issue_next = issue_reg + CW'(1);
        end
        if (cmp_status.hit_valid && cmp_status.hit) begin
            hit_next = 1'b1;
        end
        if (wr_en) begin
            count_next = count_reg + CW'(1);
        end
        if (res_load) begin
            res_next.overlaps    = hit_reg;
            res_next.stored      = wr_en;
            res_next.entry_count = COUNT_OUT_WIDTH'(count_reg + CW'(wr_en));
        end
        if (out_load) begin
            m_item_next  = res_reg;
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_en;
            m_valid_reg  <= m_valid_next;
        end
        cand_reg   <= cand_next;
        issue_reg  <= issue_next;
        hit_reg    <= hit_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `SOT_ASSERT(a_count_bound, count_reg <= CAP_C, "entry count above capacity")
    `SOT_ASSERT(a_read_in_range, rd_en |-> issue_reg < count_reg, "read of unwritten entry")
    `SOT_ASSERT(a_no_rw_overlap, wr_en |-> !rd_valid_reg && !cmp_status.busy, "append while scan in flight")
    `SOT_ASSERT(a_append_count, wr_en |=> count_reg == $past(count_reg) + CW'(1), "append did not advance count")
    `SOT_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid && count_reg == '0, "state not cleared by reset")

endmodule

### test/sot_checker.sv
// Scoreboard for the sphere overlap table: predicts each result and compares it.
module sot_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  sot_pkg::sot_in_t  s_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  sot_pkg::sot_out_t m_item,
    output int                fail_count,
    output int                pending
);
    import sot_pkg::*;

    localparam int TABLE_DEPTH = 64;

    logic [COORD_WIDTH-1:0]  tab_x [TABLE_DEPTH];
    logic [COORD_WIDTH-1:0]  tab_y [TABLE_DEPTH];
    logic [COORD_WIDTH-1:0]  tab_z [TABLE_DEPTH];
    logic [RADIUS_WIDTH-1:0] tab_r [TABLE_DEPTH];
    int                      entries;
    sot_out_t                outcome_q [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        entries    = 0;
    end

    function automatic longint unsigned axis_sq(logic [COORD_WIDTH-1:0] a,
                                                logic [COORD_WIDTH-1:0] b);
        longint unsigned ua, ub, d;
        ua = 64'(a);
        ub = 64'(b);
        d  = (ua >= ub) ? ua - ub : ub - ua;
        return d * d;
    endfunction

    // Scan the table for a hit; append the candidate when clear and not full.
    function automatic sot_out_t place_sphere(sot_in_t c);
        sot_out_t        res;
        longint unsigned dist2, rsum;
        res = '0;
        for (int i = 0; i < entries; i++) begin
            dist2 = axis_sq(c.centre_x, tab_x[i]) + axis_sq(c.centre_y, tab_y[i])
                  + axis_sq(c.centre_z, tab_z[i]);
            rsum  = longint'(c.radius) + longint'(tab_r[i]);
            if (dist2 < rsum * rsum) begin
                res.overlaps = 1'b1;
                break;
            end
        end
        if (!res.overlaps && entries < TABLE_DEPTH) begin
            tab_x[entries] = c.centre_x;
            tab_y[entries] = c.centre_y;
            tab_z[entries] = c.centre_z;
            tab_r[entries] = c.radius;
            entries++;
            res.stored = 1'b1;
        end
        res.entry_count = entries[COUNT_OUT_WIDTH-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        sot_out_t want;
        if (!aresetn) begin
            outcome_q.delete();
            entries = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (outcome_q.size() == 0) begin
                    $display("%0t: unexpected item, actual %p", $time, m_item);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    if (m_item.overlaps !== want.overlaps) begin
                        $display("%0t: overlaps expected %0d actual %0d",
                                 $time, want.overlaps, m_item.overlaps);
                        fail_count++;
                    end
                    if (m_item.stored !== want.stored) begin
                        $display("%0t: stored expected %0d actual %0d",
                                 $time, want.stored, m_item.stored);
                        fail_count++;
                    end
                    if (m_item.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, m_item.entry_count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                outcome_q.push_back(place_sphere(s_item));
            end
        end
        pending <= outcome_q.size();
    end

endmodule

### test/tb_sphere_overlap_table.sv
// Testbench top for the sphere overlap table: stimulus, back-pressure and verdict.
module tb_sphere_overlap_table;
    import sot_pkg::*;

    localparam int          ITEM_TOTAL  = 1950;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          MAX_WAIT    = 18;
    localparam int unsigned COORD_MAX   = (1 << COORD_WIDTH) - 1;
    localparam int unsigned RADIUS_MAX  = (1 << RADIUS_WIDTH) - 1;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sot_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sot_out_t m_item;
    int       fail_count;
    int       pending;
    int       cycle_count = 0;
    int       ready_wait  = 0;
    bit       s_quiet     = 1'b0;
    bit       r_quiet     = 1'b0;
    sot_in_t  sent_q [$];

    always #5 aclk = ~aclk;

    sphere_overlap_table dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    sot_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int draw_wait(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    // Result side: stall a random number of cycles after each accepted item.
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_wait <= draw_wait(1'b0);
        end else if (m_ready && m_valid) begin
            if ($urandom_range(0, 39) == 0) r_quiet = !r_quiet;
            w = draw_wait(r_quiet);
            if (w != 0) begin
                ready_wait <= w - 1;
                m_ready    <= 1'b0;
            end
        end else if (!m_ready) begin
            if (ready_wait == 0) begin
                m_ready <= 1'b1;
            end else begin
                ready_wait <= ready_wait - 1;
            end
        end
    end

    function automatic sot_in_t sphere(int unsigned x, int unsigned y, int unsigned z,
                                       int unsigned r);
        sot_in_t c;
        c.centre_x = x[COORD_WIDTH-1:0];
        c.centre_y = y[COORD_WIDTH-1:0];
        c.centre_z = z[COORD_WIDTH-1:0];
        c.radius   = r[RADIUS_WIDTH-1:0];
        return c;
    endfunction

    // Move a coordinate by d in a random direction, flipping if it would leave range.
    function automatic logic [COORD_WIDTH-1:0] shift_coord(logic [COORD_WIDTH-1:0] base,
                                                           int d);
        int b, v;
        b = int'(32'(base));
        v = $urandom_range(0, 1) ? b + d : b - d;
        if (v < 0 || v > int'(COORD_MAX)) v = (v < 0) ? b + d : b - d;
        if (v < 0) v = 0;
        if (v > int'(COORD_MAX)) v = COORD_MAX;
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic logic [COORD_WIDTH-1:0] extreme_coord();
        int unsigned v;
        case ($urandom_range(0, 3))
            0: v = 0;
            1: v = COORD_MAX;
            2: v = 1;
            default: v = $urandom_range(0, COORD_MAX);
        endcase
        return v[COORD_WIDTH-1:0];
    endfunction

    task automatic send_item(input sot_in_t it);
        int gap;
        if ($urandom_range(0, 39) == 0) s_quiet = !s_quiet;
        gap = draw_wait(s_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_q.push_back(it);
    endtask

    initial begin
        sot_in_t                cand;
        sot_in_t                h;
        logic [COORD_WIDTH-1:0] base [3];
        logic [COORD_WIDTH-1:0] pos [3];
        int                     kind, pick, sum, axis, d, span;
        bit                     touch;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // empty table, far corners, zero radii, exact touching, near misses
        send_item(sphere(COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX));
        send_item(sphere(0, 0, 0, 0));
        send_item(sphere(0, 0, 0, 0));
        send_item(sphere(0, 0, 0, 1));
        send_item(sphere(1000, 1000, 1000, 100));
        send_item(sphere(1300, 1000, 1000, 200));
        send_item(sphere(1000, 1299, 1000, 200));
        send_item(sphere(1000, 1000, 1301, 200));
        send_item(sphere(20000, 20000, 20000, 300));
        send_item(sphere(20200, 20300, 20600, 400));
        send_item(sphere(20200, 20300, 20599, 400));
        send_item(sphere(COORD_MAX - 16381, COORD_MAX, COORD_MAX, RADIUS_MAX));
        send_item(sphere(COORD_MAX - 16382, COORD_MAX, COORD_MAX, RADIUS_MAX));
        send_item(sphere('h2AAAA, 'h15555, 'h2AAAA, 'h0AAA));
        send_item(sphere('h15555, 'h2AAAA, 'h15555, 'h1555));
        send_item(sphere(COORD_MAX, 0, COORD_MAX, 0));

        while (sent_q.size() < ITEM_TOTAL) begin
            kind = $urandom_range(0, 99);
            cand.radius = RADIUS_WIDTH'(($urandom_range(0, 3) == 0)
                                        ? $urandom_range(0, 31)
                                        : $urandom_range(0, RADIUS_MAX));
            if (kind < 50) begin
                // near an earlier candidate, often exactly touching it
                span = (sent_q.size() < 96) ? sent_q.size() : 96;
                pick = ($urandom_range(0, 4) != 0) ? $urandom_range(0, span - 1)
                                                   : $urandom_range(0, sent_q.size() - 1);
                h = sent_q[pick];
                base[0] = h.centre_x;
                base[1] = h.centre_y;
                base[2] = h.centre_z;
                sum   = int'(h.radius) + int'(cand.radius);
                axis  = $urandom_range(0, 2);
                touch = 1'($urandom_range(0, 1));
                for (int a = 0; a < 3; a++) begin
                    if (a == axis) d = sum + int'($urandom_range(0, 4)) - 2;
                    else d = touch ? 0 : int'($urandom_range(0, sum / 2));
                    pos[a] = shift_coord(base[a], (d < 0) ? -d : d);
                end
                cand.centre_x = pos[0];
                cand.centre_y = pos[1];
                cand.centre_z = pos[2];
            end else if (kind < 62) begin
                cand.centre_x = extreme_coord();
                cand.centre_y = extreme_coord();
                cand.centre_z = extreme_coord();
                if ($urandom_range(0, 1)) begin
                    cand.radius = $urandom_range(0, 1) ? RADIUS_MAX[RADIUS_WIDTH-1:0] : '0;
                end
            end else begin
                cand.centre_x = COORD_WIDTH'($urandom_range(0, COORD_MAX));
                cand.centre_y = COORD_WIDTH'($urandom_range(0, COORD_MAX));
                cand.centre_z = COORD_WIDTH'($urandom_range(0, COORD_MAX));
            end
            send_item(cand);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
